// File: hdl/mf3_pkg.sv
// Shared types, constants and median network helpers for the 3x3 median filter.
// No dependencies; every module of the filter imports this package.
package mf3_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int SIZE_W       = 11;
  localparam int COORD_W      = 10;
  localparam int PIX_W        = 8;
  localparam int WIN_PIXELS   = 9;
  localparam int MID_RANK     = 4;

  // The job queue depth must be a power of two so the pointers wrap naturally.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_PIXELS-1:0] win_t;

  typedef struct packed {
    win_t               win;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int hi);
    if (v < SIZE_W'(3)) begin
      return SIZE_W'(3);
    end else if (int'(v) > hi) begin
      return SIZE_W'(hi);
    end
    return v;
  endfunction

  // Compare-exchange: the smaller value ends up at position a.
  function automatic win_t order_pair(win_t w, int a, int b);
    pix_t t;
    if (w[a] > w[b]) begin
      t    = w[a];
      w[a] = w[b];
      w[b] = t;
    end
    return w;
  endfunction

  // Sort each column of three.
  function automatic win_t med_part_a(win_t w);
    win_t r;
    r = w;
    r = order_pair(r, 1, 2); r = order_pair(r, 4, 5); r = order_pair(r, 7, 8);
    r = order_pair(r, 0, 1); r = order_pair(r, 3, 4); r = order_pair(r, 6, 7);
    r = order_pair(r, 1, 2); r = order_pair(r, 4, 5); r = order_pair(r, 7, 8);
    return r;
  endfunction

  function automatic win_t med_part_b(win_t w);
    win_t r;
    r = w;
    r = order_pair(r, 0, 3); r = order_pair(r, 5, 8); r = order_pair(r, 4, 7);
    r = order_pair(r, 3, 6); r = order_pair(r, 1, 4); r = order_pair(r, 2, 5);
    return r;
  endfunction

  function automatic pix_t med_part_c(win_t w);
    win_t r;
    r = w;
    r = order_pair(r, 4, 7); r = order_pair(r, 4, 2);
    r = order_pair(r, 6, 4); r = order_pair(r, 4, 2);
    return r[MID_RANK];
  endfunction

endpackage

// File: hdl/median_filter_3x3.sv
// Top level of the 3x3 median filter: front end, job queue and median pipeline.
// Depends on mf3_pkg, mf3_front, mf3_queue and mf3_back.
//
//  Channel   Direction  Handshake                  Payload
//  cfg       in         cfg_we_i                   cfg_idx_i, cfg_data_i
//  in        in         in_valid_i / in_ready_o    pixel_i
//  out       out        out_valid_o / out_ready_i  median_value_o, center_x_o,
//                                                  center_y_o, frame_last_o
//
// One pixel per clock is taken while the job queue has room; out_valid_o for a
// result rises at the earliest once its pixel has passed the line store read,
// the queue, two network stages and the output register.
// Reset clears counters, window and pipeline; the line stores are not cleared,
// since no value read from an entry is used before the row above has written it.
// A stalled output fills the four-entry queue, after which in_ready_o drops.
module median_filter_3x3
  import mf3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [SIZE_W-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PIX_W-1:0]   pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PIX_W-1:0]   median_value_o,
  output logic [COORD_W-1:0] center_x_o,
  output logic [COORD_W-1:0] center_y_o,
  output logic               frame_last_o
);

  push_t             push;
  job_t              head;
  logic              q_valid, pop;
  logic [QCNT_W-1:0] q_count;

  mf3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_i),
    .q_count_i  (q_count),
    .push_o     (push)
  );

  mf3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head),
    .count_o (q_count)
  );

  mf3_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_value_o (median_value_o),
    .center_x_o     (center_x_o),
    .center_y_o     (center_y_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

// File: hdl/mf3_front.sv
// Front end of the median filter: pixel intake, raster counters, line stores
// and the window registers. Depends on mf3_pkg; feeds jobs to mf3_queue.
module mf3_front
  import mf3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_t              pixel_i,
  input  logic [QCNT_W-1:0] q_count_i,
  output push_t             push_o
);

  logic [SIZE_W-1:0]  w_lim_q, h_lim_q;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic               s1_valid_q, s1_emit_q, s1_last_q;
  logic [COORD_W-1:0] s1_cx_q, s1_cy_q;
  logic [ADDR_W-1:0]  s1_slot_q;
  pix_t               s1_px_q, top_rd_q, mid_rd_q;
  pix_t [5:0]         win_q;
  pix_t               upper_mem  [MAX_WIDTH];
  pix_t               middle_mem [MAX_WIDTH];

  logic              accept, emit, col_end, frame_end;
  logic [ADDR_W-1:0] slot;
  logic [QCNT_W:0]   occ;

  // A job in the read stage still has to land in the queue, so it counts
  // against the free space.
  assign occ        = {1'b0, q_count_i} + {{QCNT_W{1'b0}}, s1_valid_q & s1_emit_q};
  assign in_ready_o = occ < (QCNT_W + 1)'(QDEPTH);
  assign accept     = in_valid_i & in_ready_o;

  assign slot      = ADDR_W'(x_q);
  assign emit      = (x_q >= COORD_W'(2)) && (y_q >= COORD_W'(2));
  assign col_end   = ({1'b0, x_q} + SIZE_W'(1)) >= w_lim_q;
  assign frame_end = col_end && (({1'b0, y_q} + SIZE_W'(1)) >= h_lim_q);

  always_comb begin
    x_d = x_q + COORD_W'(1);
    y_d = y_q;
    if (frame_end) begin
      x_d = '0;
      y_d = '0;
    end else if (col_end) begin
      x_d = '0;
      y_d = y_q + COORD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_lim_q <= WIDTH_RESET;
      h_lim_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  w_lim_q <= clamp_size(cfg_data_i, MAX_WIDTH);
        CFG_HEIGHT: h_lim_q <= clamp_size(cfg_data_i, MAX_HEIGHT);
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      y_q        <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        x_q       <= x_d;
        y_q       <= y_d;
        s1_emit_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_slot_q <= slot;
      s1_cx_q   <= x_q - COORD_W'(1);
      s1_cy_q   <= y_q - COORD_W'(1);
      s1_last_q <= frame_end;
    end
  end

  // Both stores are read at the current column; the middle store takes the
  // new pixel in the same beat, the upper store takes the old middle value
  // in the following cycle, once its read data is back.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_rd_q         <= upper_mem[slot];
      mid_rd_q         <= middle_mem[slot];
      middle_mem[slot] <= pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      upper_mem[s1_slot_q] <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q[2:0] <= win_q[5:3];
      win_q[3]   <= top_rd_q;
      win_q[4]   <= mid_rd_q;
      win_q[5]   <= s1_px_q;
    end
  end

  always_comb begin
    push_o.valid    = s1_valid_q & s1_emit_q;
    push_o.job.win  = {s1_px_q, mid_rd_q, top_rd_q, win_q};
    push_o.job.cx   = s1_cx_q;
    push_o.job.cy   = s1_cy_q;
    push_o.job.last = s1_last_q;
  end

endmodule

// File: hdl/mf3_queue.sv
// Short job queue between the front end and the median pipeline.
// Depends on mf3_pkg; the front end never pushes into a full queue.
module mf3_queue
  import mf3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  input  logic              pop_i,
  output logic              valid_o,
  output job_t              head_o,
  output logic [QCNT_W-1:0] count_o
);

  job_t              store_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign valid_o = count_q != '0;
  assign head_o  = store_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      store_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      unique case ({push_i.valid, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: hdl/mf3_back.sv
// Back end of the median filter: a three-part median network whose last part
// loads the output register. Depends on mf3_pkg; pulls jobs from mf3_queue.
module mf3_back
  import mf3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  job_t               head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pix_t               median_value_o,
  output logic [COORD_W-1:0] center_x_o,
  output logic [COORD_W-1:0] center_y_o,
  output logic               frame_last_o
);

  logic               a_valid_q, b_valid_q, out_valid_q;
  job_t               a_q, b_q;
  job_t               a_d, b_d;
  pix_t               med_q;
  logic [COORD_W-1:0] cx_q, cy_q;
  logic               last_q;
  logic               out_ld, b_ready, a_ready;

  // Each stage moves on when it is empty or the next one moves on.
  assign out_ld  = !out_valid_q || out_ready_i;
  assign b_ready = !b_valid_q || out_ld;
  assign a_ready = !a_valid_q || b_ready;
  assign pop_o   = q_valid_i && a_ready;

  always_comb begin
    a_d     = head_i;
    a_d.win = med_part_a(head_i.win);
    b_d     = a_q;
    b_d.win = med_part_b(a_q.win);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= q_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (out_ld) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_q <= a_d;
    end
    if (a_valid_q && b_ready) begin
      b_q <= b_d;
    end
    if (b_valid_q && out_ld) begin
      med_q  <= med_part_c(b_q.win);
      cx_q   <= b_q.cx;
      cy_q   <= b_q.cy;
      last_q <= b_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_value_o = med_q;
  assign center_x_o     = cx_q;
  assign center_y_o     = cy_q;
  assign frame_last_o   = last_q;

endmodule

// File: hdl/mf3_checker.sv
// Port-level checks for the 3x3 median filter, bound to median_filter_3x3.
// Depends on mf3_pkg; sees only the top level's ports.
module mf3_checker
  import mf3_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [PIX_W-1:0]   median_value_o,
  input logic [COORD_W-1:0] center_x_o,
  input logic [COORD_W-1:0] center_y_o,
  input logic               frame_last_o
);

  logic [31:0] in_cnt_q, out_cnt_q;
  logic        in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (in_beat) begin
        in_cnt_q <= in_cnt_q + 32'd1;
      end
      if (out_beat) begin
        out_cnt_q <= out_cnt_q + 32'd1;
      end
    end
  end

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(median_value_o) &&
    $stable(center_x_o) && $stable(center_y_o) && $stable(frame_last_o))
    else $error("result changed while stalled");

  // Pixels in the first row or the first column are never centers.
  a_no_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> center_x_o != '0 && center_y_o != '0)
    else $error("result centered on the border");

  // Every result follows the pixel that completes its window.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> out_cnt_q < in_cnt_q)
    else $error("more results than pixels");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .median_value_o (median_value_o),
  .center_x_o     (center_x_o),
  .center_y_o     (center_y_o),
  .frame_last_o   (frame_last_o)
);
